### src/lowbit_embedding_dequant_macros.svh
// Assertion helpers for the embedding dequantizer.
`ifndef LOWBIT_EMBEDDING_DEQUANT_MACROS_SVH
`define LOWBIT_EMBEDDING_DEQUANT_MACROS_SVH

`ifndef ASSERT_OFF
`define LBED_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define LBED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`define LBED_ASSERT_DELAY2(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
		else $error("two-cycle check failed");
`else
`define LBED_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LBED_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define LBED_ASSERT_DELAY2(label, clk, rst_n, ante, cons)
`endif

`endif

### src/lbed_pkg.sv
package lbed_pkg;

	localparam int NUM_ROWS   = 256;
	localparam int MAX_DIM    = 64;
	localparam int MAX_GROUPS = 8;
	localparam int ROW_BYTES  = (MAX_DIM + 1) / 2;

	localparam int ROW_W  = $clog2(NUM_ROWS);
	localparam int COL_W  = $clog2(ROW_BYTES);
	localparam int GRP_W  = $clog2(MAX_GROUPS);
	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int DIM_W  = IDX_W + 1;
	localparam int WT_AW  = ROW_W + COL_W;
	localparam int PAR_AW = ROW_W + GRP_W;
	localparam int CFG_W  = 7;
	localparam int CFG_IW = 2;

	// Operation codes.
	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_SCALE  = 2'd1;
	localparam logic [1:0] OP_ZP     = 2'd2;
	localparam logic [1:0] OP_LOOKUP = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IW-1:0] REG_NBIT_MODE = 2'd0;
	localparam logic [CFG_IW-1:0] REG_DIM       = 2'd1;
	localparam logic [CFG_IW-1:0] REG_GROUPS    = 2'd2;
	localparam logic [CFG_IW-1:0] REG_ZP_EN     = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  row;
		logic [4:0]  column;
		logic [15:0] value;
	} item_t;

	typedef struct packed {
		logic signed [32:0] result_value;
		logic [5:0]         element_index;
		logic               last;
	} result_t;

	// Control that travels with the memory read of one element.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] element_index;
		logic             last;
		logic             nbit;
		logic [1:0]       pos;
		logic             zp_en;
	} elem_ctl_t;

endpackage

### src/lbed_mac.sv
module lbed_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  lbed_pkg::elem_ctl_t ctl,
	input  logic [7:0]          wt_byte,
	input  logic [15:0]         scale,
	input  logic [15:0]         zp_word,
	output logic                strobe,
	output lbed_pkg::result_t   result
);

	logic [3:0]         nib;
	logic [1:0]         pair;
	logic signed [3:0]  w;
	logic signed [15:0] zp;
	logic signed [16:0] diff;
	logic signed [32:0] diff_x;
	logic signed [32:0] scale_x;
	logic signed [32:0] prod;
	logic               strobe_s2;
	lbed_pkg::result_t  res_s2;

	always_comb begin
		nib  = ctl.pos[0] ? wt_byte[3:0] : wt_byte[7:4];
		case (ctl.pos)
			2'd0: pair = wt_byte[1:0];
			2'd1: pair = wt_byte[3:2];
			2'd2: pair = wt_byte[5:4];
			default: pair = wt_byte[7:6];
		endcase
		// Subtracting the offset flips the top bit of the unsigned code.
		if (ctl.nbit) begin
			w = $signed({~nib[3], nib[2:0]});
		end else begin
			w = $signed({{2{~pair[1]}}, ~pair[1], pair[0]});
		end
		zp      = ctl.zp_en ? $signed(zp_word) : 16'sd0;
		diff    = $signed({{5{w[3]}}, w, 8'd0}) - $signed({zp[15], zp});
		diff_x  = 33'(diff);
		scale_x = 33'($signed(scale));
		prod    = diff_x * scale_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s2 <= 1'b0;
		end else begin
			strobe_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		res_s2.result_value  <= prod;
		res_s2.element_index <= ctl.element_index;
		res_s2.last          <= ctl.last;
	end

	assign strobe = strobe_s2;
	assign result = res_s2;

endmodule

### src/lowbit_embedding_dequant.sv
// Group-wise quantized embedding table with lookup. Writes of weight bytes, scales and
// zero points take one cycle each. A lookup keeps busy high for one cycle per element of
// the row (the configured row length, 1 to 64), because every element goes through the same
// memory read ports and the single shared multiplier; its results follow two cycles after
// each element's read, one per cycle, as single-cycle strobe pulses that the receiver
// must take as they come. A new item may be started as soon as busy falls. The tables are
// not cleared at reset: look up only rows whose bytes, scales and zero points were written.
`include "lowbit_embedding_dequant_macros.svh"

module lowbit_embedding_dequant (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  lbed_pkg::item_t                       item,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lbed_pkg::CFG_IW-1:0]           cfg_index,
	input  logic [lbed_pkg::CFG_W-1:0]            cfg_data,
	output logic                                  strobe,
	output lbed_pkg::result_t                     result
);

	logic                          nbit_q;
	logic [lbed_pkg::DIM_W-1:0]    dim_cfg_q;
	logic [1:0]                    glog2_q;
	logic                          zp_en_q;

	logic                          accept;
	logic                          wr_weight;
	logic                          wr_par;
	logic                          lookup_go;

	logic                          active_q;
	logic [lbed_pkg::ROW_W-1:0]    row_q;
	logic [lbed_pkg::IDX_W-1:0]    j_q;
	logic [lbed_pkg::IDX_W-1:0]    last_j_q;
	logic [lbed_pkg::GRP_W-1:0]    g_q;
	logic [lbed_pkg::GRP_W-1:0]    g_last_q;
	logic [lbed_pkg::DIM_W-1:0]    gcnt_q;
	logic [lbed_pkg::DIM_W-1:0]    gsize_q;

	logic [lbed_pkg::DIM_W-1:0]    dim_eff;
	logic [lbed_pkg::DIM_W-1:0]    gsize_raw;
	logic                          issue_last;

	logic [lbed_pkg::WT_AW-1:0]    wt_raddr;
	logic [lbed_pkg::PAR_AW-1:0]   par_raddr;

	logic [7:0]  wt_mem  [lbed_pkg::NUM_ROWS * lbed_pkg::ROW_BYTES];
	logic [15:0] sc_mem  [lbed_pkg::NUM_ROWS * lbed_pkg::MAX_GROUPS];
	logic [15:0] zp_mem  [lbed_pkg::NUM_ROWS * lbed_pkg::MAX_GROUPS];

	logic [7:0]            wt_byte_s1;
	logic [15:0]           scale_s1;
	logic [15:0]           zp_s1;
	lbed_pkg::elem_ctl_t   ctl_s1;

	assign cfg_ready = 1'b1;
	assign busy      = active_q;
	assign accept    = start && !active_q;
	assign wr_weight = accept && (item.operation == lbed_pkg::OP_WEIGHT);
	assign wr_par    = accept && (item.column < 5'(lbed_pkg::MAX_GROUPS))
		&& ((item.operation == lbed_pkg::OP_SCALE) || (item.operation == lbed_pkg::OP_ZP));
	assign lookup_go = accept && (item.operation == lbed_pkg::OP_LOOKUP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbit_q    <= 1'b1;
			dim_cfg_q <= 7'(lbed_pkg::MAX_DIM);
			glog2_q   <= 2'd0;
			zp_en_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lbed_pkg::REG_NBIT_MODE: nbit_q    <= cfg_data[0];
				lbed_pkg::REG_DIM:       dim_cfg_q <= cfg_data;
				lbed_pkg::REG_GROUPS:    glog2_q   <= cfg_data[1:0];
				lbed_pkg::REG_ZP_EN:     zp_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (dim_cfg_q == '0) begin
			dim_eff = 7'd1;
		end else if (dim_cfg_q > 7'(lbed_pkg::MAX_DIM)) begin
			dim_eff = 7'(lbed_pkg::MAX_DIM);
		end else begin
			dim_eff = dim_cfg_q;
		end
		gsize_raw = dim_eff >> glog2_q;
	end

	assign issue_last = (j_q == last_j_q);

	// Sequencer: one element per cycle, group tracked by counting elements
	// so that no division is needed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (lookup_go) begin
			active_q <= 1'b1;
		end else if (active_q && issue_last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_go) begin
			row_q    <= item.row;
			j_q      <= '0;
			g_q      <= '0;
			gcnt_q   <= '0;
			last_j_q <= 6'(dim_eff - 7'd1);
			g_last_q <= 3'((4'd1 << glog2_q) - 4'd1);
			gsize_q  <= (gsize_raw == '0) ? 7'd1 : gsize_raw;
		end else if (active_q) begin
			j_q <= j_q + 6'd1;
			if (gcnt_q == gsize_q - 7'd1) begin
				gcnt_q <= '0;
				if (g_q != g_last_q) begin
					g_q <= g_q + 3'd1;
				end
			end else begin
				gcnt_q <= gcnt_q + 7'd1;
			end
		end
	end

	assign wt_raddr  = nbit_q ? {row_q, j_q[5:1]} : {row_q, 1'b0, j_q[5:2]};
	assign par_raddr = {row_q, g_q};

	always_ff @(posedge clk) begin
		if (wr_weight) begin
			wt_mem[{item.row, item.column}] <= item.value[7:0];
		end
		wt_byte_s1 <= wt_mem[wt_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr_par && (item.operation == lbed_pkg::OP_SCALE)) begin
			sc_mem[{item.row, item.column[2:0]}] <= item.value;
		end
		scale_s1 <= sc_mem[par_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr_par && (item.operation == lbed_pkg::OP_ZP)) begin
			zp_mem[{item.row, item.column[2:0]}] <= item.value;
		end
		zp_s1 <= zp_mem[par_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid         <= active_q;
			ctl_s1.element_index <= j_q;
			ctl_s1.last          <= issue_last;
			ctl_s1.nbit          <= nbit_q;
			ctl_s1.pos           <= nbit_q ? {1'b0, j_q[0]} : j_q[1:0];
			ctl_s1.zp_en         <= zp_en_q;
		end
	end

	lbed_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_s1),
		.wt_byte    (wt_byte_s1),
		.scale      (scale_s1),
		.zp_word    (zp_s1),
		.strobe     (strobe),
		.result     (result)
	);

	`LBED_ASSERT_NEXT(a_lookup_busy, clk, arst_n, lookup_go, busy)
	`LBED_ASSERT_DELAY2(a_issue_result, clk, arst_n, active_q, strobe)
	`LBED_ASSERT_NEXT(a_last_ends, clk, arst_n, active_q && issue_last, !active_q)
	`LBED_ASSERT_IMPL(a_last_flag, clk, arst_n, strobe && result.last, $past(ctl_s1.valid))

endmodule

### verif/lowbit_embedding_dequant_checker.sv
`timescale 1ns / 1ps

module lowbit_embedding_dequant_checker
	import lbed_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  item_t               item,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                strobe,
	input  result_t             result,
	output int                  fails,
	output int                  pending
);

	logic [7:0]  weight_mem [NUM_ROWS][ROW_BYTES];
	logic [15:0] scale_mem  [NUM_ROWS][MAX_GROUPS];
	logic [15:0] zp_mem     [NUM_ROWS][MAX_GROUPS];

	logic       nbit_q;
	logic [6:0] dim_q;
	logic [1:0] glog2_q;
	logic       zp_en_q;

	result_t elem_q[$];
	int      fail_cnt;

	// Expands one row lookup into its dequantized elements, in element order.
	function automatic void dequant_row(input logic [7:0] r);
		int                 d;
		int                 groups;
		int                 gsize;
		int                 g;
		int                 w;
		int                 zp;
		int                 sc;
		logic [7:0]         b;
		logic signed [15:0] s16;
		logic signed [63:0] prod;
		result_t            e;
		d = (dim_q == 7'd0) ? 1 : ((int'(dim_q) > MAX_DIM) ? MAX_DIM : int'(dim_q));
		groups = 1 << glog2_q;
		if (groups > MAX_GROUPS)
			groups = MAX_GROUPS;
		gsize = d / groups;
		if (gsize == 0)
			gsize = 1;
		for (int j = 0; j < d; j++) begin
			g = j / gsize;
			if (g >= groups)
				g = groups - 1;
			if (nbit_q) begin
				// Even elements sit in the high nibble.
				b = weight_mem[r][j >> 1];
				w = ((j & 1) != 0) ? int'(b[3:0]) - 8 : int'(b[7:4]) - 8;
			end else begin
				b = weight_mem[r][j >> 2];
				w = int'((b >> (2 * (j & 3))) & 8'h03) - 2;
			end
			s16 = scale_mem[r][g];
			sc = s16;
			s16 = zp_mem[r][g];
			zp = zp_en_q ? int'(s16) : 0;
			prod = (longint'(w) * 256 - longint'(zp)) * longint'(sc);
			e.result_value = prod[32:0];
			e.element_index = 6'(j);
			e.last = (j == d - 1);
			elem_q.push_back(e);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			elem_q.delete();
			nbit_q = 1'b1;
			dim_q = 7'd64;
			glog2_q = 2'd0;
			zp_en_q = 1'b0;
			fail_cnt = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			// Results are checked before a lookup accepted at the same edge is expanded.
			if (strobe) begin
				if (elem_q.size() == 0) begin
					$error("unexpected result transfer: element_index %0d",
						result.element_index);
					fail_cnt++;
				end else begin
					want = elem_q.pop_front();
					if (result.result_value !== want.result_value) begin
						$error("result_value: expected %0d, actual %0d",
							want.result_value, result.result_value);
						fail_cnt++;
					end
					if (result.element_index !== want.element_index) begin
						$error("element_index: expected %0d, actual %0d",
							want.element_index, result.element_index);
						fail_cnt++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, result.last);
						fail_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_NBIT_MODE: nbit_q = cfg_data[0];
					REG_DIM:       dim_q = cfg_data[6:0];
					REG_GROUPS:    glog2_q = cfg_data[1:0];
					REG_ZP_EN:     zp_en_q = cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (item.operation)
					OP_WEIGHT: begin
						if (int'(item.column) < ROW_BYTES)
							weight_mem[item.row][item.column] = item.value[7:0];
					end
					OP_SCALE: begin
						if (int'(item.column) < MAX_GROUPS)
							scale_mem[item.row][item.column] = item.value;
					end
					OP_ZP: begin
						if (int'(item.column) < MAX_GROUPS)
							zp_mem[item.row][item.column] = item.value;
					end
					OP_LOOKUP: dequant_row(item.row);
					default: ;
				endcase
			end
			fails <= fail_cnt;
			pending <= elem_q.size();
		end
	end

endmodule

### verif/lowbit_embedding_dequant_tb.sv
`timescale 1ns / 1ps

module lowbit_embedding_dequant_tb;
	import lbed_pkg::*;

	localparam int NUM_SETTINGS = 10;
	localparam int ITEMS_PER_SETTING = 12;
	localparam int CYCLE_LIMIT = 300000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	item_t             item;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              strobe;
	result_t           result;
	int                fails;
	int                pending;

	// Which table entries have been written; lookups only touch rows that are complete.
	bit wt_done [NUM_ROWS][ROW_BYTES];
	bit sc_done [NUM_ROWS][MAX_GROUPS];
	bit zp_done [NUM_ROWS][MAX_GROUPS];

	bit         cur_nbit;
	logic [6:0] cur_dim;
	logic [1:0] cur_glog2;
	int         idle_pct;
	int         sent;
	int         cycles = 0;
	logic [7:0] row_pool [8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd127, 8'd128, 8'd254, 8'd255};

	lowbit_embedding_dequant u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.strobe    (strobe),
		.result    (result)
	);

	lowbit_embedding_dequant_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.strobe    (strobe),
		.result    (result),
		.fails     (fails),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("lowbit_embedding_dequant: mismatch");
			$finish;
		end
	end

	function automatic int row_bytes_used();
		int d;
		d = (cur_dim == 7'd0) ? 1 : ((int'(cur_dim) > MAX_DIM) ? MAX_DIM : int'(cur_dim));
		return cur_nbit ? (d + 1) / 2 : (d + 3) / 4;
	endfunction

	function automatic logic [15:0] pick_param();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic issue(input logic [1:0] op, input logic [7:0] r, input logic [4:0] c,
			input logic [15:0] v);
		item_t it;
		it.operation = op;
		it.row = r;
		it.column = c;
		it.value = v;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		case (op)
			OP_WEIGHT: wt_done[r][c] = 1'b1;
			OP_SCALE: if (int'(c) < MAX_GROUPS) sc_done[r][c] = 1'b1;
			OP_ZP: if (int'(c) < MAX_GROUPS) zp_done[r][c] = 1'b1;
			default: ;
		endcase
		if (op == OP_WEIGHT || op == OP_LOOKUP || int'(c) < MAX_GROUPS)
			sent++;
	endtask

	task automatic lookup(input logic [7:0] r);
		issue(OP_LOOKUP, r, 5'($urandom), 16'($urandom));
	endtask

	// Writes whatever the current setting needs and is still missing, then a few updates.
	task automatic prepare_row(input logic [7:0] r);
		int nb;
		int ng;
		nb = row_bytes_used();
		ng = 1 << cur_glog2;
		for (int c = 0; c < nb; c++)
			if (!wt_done[r][c])
				issue(OP_WEIGHT, r, 5'(c), 16'($urandom));
		for (int g = 0; g < ng; g++) begin
			if (!sc_done[r][g])
				issue(OP_SCALE, r, 5'(g), pick_param());
			if (!zp_done[r][g])
				issue(OP_ZP, r, 5'(g), pick_param());
		end
		repeat ($urandom_range(4)) begin
			case ($urandom_range(2))
				0: issue(OP_WEIGHT, r, 5'($urandom_range(nb - 1)), 16'($urandom));
				1: issue(OP_SCALE, r, 5'($urandom_range(ng - 1)), pick_param());
				default: issue(OP_ZP, r, 5'($urandom_range(ng - 1)), pick_param());
			endcase
		end
	endtask

	// Waits until every expected element has arrived and the block has gone quiet.
	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input bit nb, input logic [6:0] d, input logic [1:0] gl,
			input bit zp);
		quiesce();
		// Unused upper data bits are randomized; only the low bits should count.
		write_reg(REG_NBIT_MODE, {6'($urandom), nb});
		write_reg(REG_DIM, d);
		write_reg(REG_GROUPS, {5'($urandom), gl});
		write_reg(REG_ZP_EN, {6'($urandom), zp});
		cfg_valid <= 1'b0;
		cur_nbit = nb;
		cur_dim = d;
		cur_glog2 = gl;
	endtask

	initial begin
		logic [7:0] r;
		int target;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 7;
		sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Four-bit weights, two groups, zero point on: nibble and parameter extremes.
		set_config(1'b1, 7'd4, 2'd1, 1'b1);
		issue(OP_WEIGHT, 8'd255, 5'd0, 16'hABF0);
		issue(OP_WEIGHT, 8'd255, 5'd1, 16'h007F);
		issue(OP_SCALE, 8'd255, 5'd0, 16'h8000);
		issue(OP_SCALE, 8'd255, 5'd1, 16'h7FFF);
		issue(OP_ZP, 8'd255, 5'd0, 16'h7FFF);
		issue(OP_ZP, 8'd255, 5'd1, 16'h8000);
		// Group numbers past the table must leave stored parameters alone.
		issue(OP_SCALE, 8'd255, 5'd8, 16'h1234);
		issue(OP_ZP, 8'd255, 5'd31, 16'hFFFF);
		lookup(8'd255);
		lookup(8'd255);

		// Two-bit weights, uneven groups so the last element saturates, zero point off.
		set_config(1'b0, 7'd9, 2'd2, 1'b0);
		issue(OP_WEIGHT, 8'd0, 5'd0, 16'hFFE4);
		issue(OP_WEIGHT, 8'd0, 5'd1, 16'h001B);
		issue(OP_WEIGHT, 8'd0, 5'd2, 16'h00FF);
		issue(OP_SCALE, 8'd0, 5'd0, 16'h1000);
		issue(OP_SCALE, 8'd0, 5'd1, 16'hF000);
		issue(OP_SCALE, 8'd0, 5'd2, 16'h0001);
		issue(OP_SCALE, 8'd0, 5'd3, 16'hFFFF);
		issue(OP_ZP, 8'd0, 5'd0, 16'h0180);
		issue(OP_ZP, 8'd0, 5'd1, 16'h8000);
		issue(OP_ZP, 8'd0, 5'd2, 16'h7FFF);
		issue(OP_ZP, 8'd0, 5'd3, 16'hFF00);
		lookup(8'd0);

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			idle_pct = (s < 4) ? 7 : ((s < 7) ? 71 : 0);
			case (s)
				0: set_config(1'b1, 7'd64, 2'd3, 1'b1);
				1: set_config(1'b0, 7'd0, 2'd0, 1'b0);
				2: set_config(1'b1, 7'd127, 2'd2, 1'b1);
				3: set_config(1'b0, 7'd64, 2'd3, 1'b1);
				4: set_config(1'b1, 7'd1, 2'd3, 1'b0);
				default: set_config(1'($urandom), ($urandom_range(3) == 0) ?
					7'($urandom_range(127)) : 7'($urandom_range(1, 16)),
					2'($urandom), 1'($urandom));
			endcase
			target = sent + ITEMS_PER_SETTING;
			while (sent < target) begin
				if ($urandom_range(99) < 80) begin
					r = row_pool[$urandom_range(7)];
					prepare_row(r);
					lookup(r);
					if ($urandom_range(99) < 30)
						lookup(r);
				end else begin
					issue(2'($urandom_range(2)), 8'($urandom), 5'($urandom), 16'($urandom));
				end
			end
		end

		quiesce();
		if (fails == 0)
			$display("lowbit_embedding_dequant: match");
		else
			$display("lowbit_embedding_dequant: mismatch");
		$finish;
	end

endmodule
